@@ rtl/core/adbds_pkg.sv @@
// adbds_pkg: shared widths, register codes, controller states and the
// command/status structs of the ADC block averager with deadband and rescale.
// No dependencies.
`default_nettype none

package adbds_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 14;
  localparam int CH_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * SAMPLE_W;

  // Frame shape: every channel is sampled ROUNDS times per frame
  localparam int ROUNDS    = 4;
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int AVG_SHIFT = $clog2(ROUNDS);

  // Constants and register reset values
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;
  localparam logic [SAMPLE_W-1:0] LOW_RST    = 12'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_RST   = 12'd4095;
  localparam logic [SAMPLE_W-1:0] THR_RST    = 12'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SCAN,
    ST_SEL,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic acc_en;   // add sample into the selected channel sum
    logic scan_en;  // record deadband decision for the selected channel
    logic sel_en;   // clear sum, publish average, launch rescale
    logic emit_en;  // load the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic mask_hit;  // selected channel publishes this frame
    logic div_busy;  // rescale divider running
    logic out_free;  // output register can take a new result
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/adbds_ctrl.sv @@
// adbds_ctrl: sequencer for sample accumulation and the per-frame evaluation
// passes (deadband scan, then publish/rescale/emit). Depends on adbds_pkg.
`default_nettype none

module adbds_ctrl #(
  parameter int CHANNELS = 4,
  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  adbds_pkg::status_t     status,
  output adbds_pkg::cmd_t        cmd,
  output logic [IDXW-1:0]        sel_idx
);
  import adbds_pkg::*;

  localparam logic [IDXW-1:0]  LAST_CH  = IDXW'(CHANNELS - 1);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  state_t            state_r, state_nxt;
  logic [IDXW-1:0]   ch_r, ch_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [IDXW-1:0]   idx_r, idx_nxt;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      ch_r    <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_ACCUM: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (ch_r == LAST_CH) begin
            ch_nxt = '0;
            if (rnd_r == LAST_RND) begin
              // frame complete
              rnd_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end else begin
              rnd_nxt = rnd_r + RND_W'(1);
            end
          end else begin
            ch_nxt = ch_r + IDXW'(1);
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (idx_r == LAST_CH) begin
          idx_nxt   = '0;
          state_nxt = ST_SEL;
        end else begin
          idx_nxt = idx_r + IDXW'(1);
        end
      end
      ST_SEL: begin
        cmd.sel_en = 1'b1;
        if (status.mask_hit) begin
          state_nxt = ST_DIV;
        end else if (idx_r == LAST_CH) begin
          idx_nxt   = '0;
          state_nxt = ST_ACCUM;
        end else begin
          idx_nxt = idx_r + IDXW'(1);
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_en = 1'b1;
          if (idx_r == LAST_CH) begin
            idx_nxt   = '0;
            state_nxt = ST_ACCUM;
          end else begin
            idx_nxt   = idx_r + IDXW'(1);
            state_nxt = ST_SEL;
          end
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  // Sum index during accumulation, channel index during evaluation
  assign sel_idx = (state_r == ST_ACCUM) ? ch_r : idx_r;

endmodule

`default_nettype wire

@@ rtl/core/adbds_div.sv @@
// adbds_div: restoring divider, one quotient bit per cycle, for the rescale
// quotient. Quotient is known to fit SAMPLE_W bits. Depends on adbds_pkg.
`default_nettype none

module adbds_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [adbds_pkg::PROD_W-1:0]        num,
  input  wire logic [adbds_pkg::SAMPLE_W-1:0]      den,
  output logic                                     busy,
  output logic [adbds_pkg::SAMPLE_W-1:0]           quo
);
  import adbds_pkg::*;

  localparam int STEPS = SAMPLE_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  logic [SAMPLE_W-1:0] rem_r, low_r, quo_r, den_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   trial_sub;
  logic                ge;

  // One shift-subtract step
  assign trial     = {rem_r, low_r[SAMPLE_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = (trial >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient; upper half of num is below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[PROD_W-1:SAMPLE_W];
      low_r <= num[SAMPLE_W-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      low_r <= {low_r[SAMPLE_W-2:0], 1'b0};
      quo_r <= {quo_r[SAMPLE_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

@@ rtl/core/adbds_dp.sv @@
// adbds_dp: configuration registers, channel sums, published averages,
// deadband compare, rescale and output register. Depends on adbds_pkg, adbds_div.
`default_nettype none

module adbds_dp #(
  parameter int CHANNELS = 4,
  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [adbds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [adbds_pkg::SAMPLE_W-1:0]      cfg_data,
  input  wire logic [adbds_pkg::SAMPLE_W-1:0]      in_sample,
  input  adbds_pkg::cmd_t                          cmd,
  input  wire logic [IDXW-1:0]                     sel_idx,
  output adbds_pkg::status_t                       status,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [adbds_pkg::CH_W-1:0]               out_channel,
  output logic [adbds_pkg::SAMPLE_W-1:0]           out_scaled_value,
  output logic                                     out_last_of_run
);
  import adbds_pkg::*;

  logic [SAMPLE_W-1:0] low_r, high_r, thr_r;
  logic [SUM_W-1:0]    sum_r [CHANNELS];
  logic [SAMPLE_W-1:0] pub_r [CHANNELS];
  logic [CHANNELS-1:0] mask_r;

  logic                direct_r;
  logic [SAMPLE_W-1:0] direct_val_r;
  logic                out_valid_r;
  logic [CH_W-1:0]     out_channel_r;
  logic [SAMPLE_W-1:0] out_value_r;
  logic                out_last_r;

  logic [SUM_W-1:0]    sum_sel;
  logic [SAMPLE_W-1:0] avg, pub_sel, diff, x, den;
  logic [PROD_W-1:0]   num;
  logic                flag, below, in_window, hit, div_start, div_busy, mask_above;
  logic                out_free;
  logic [SAMPLE_W-1:0] quo;

  // Selected channel: average and deadband decision
  assign sum_sel = sum_r[sel_idx];
  assign pub_sel = pub_r[sel_idx];
  assign avg     = sum_sel[AVG_SHIFT +: SAMPLE_W];
  assign diff    = (avg > pub_sel) ? (avg - pub_sel) : (pub_sel - avg);
  assign flag    = (diff > thr_r);
  assign hit     = mask_r[sel_idx];

  // Rescale window: (avg - low) * 4095 / (high - low)
  assign below     = (avg < low_r);
  assign in_window = !below && (avg < high_r);
  assign x         = avg - low_r;
  assign num       = {x, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, x};
  assign den       = high_r - low_r;
  assign div_start = cmd.sel_en && hit && in_window;

  adbds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Any later channel still to publish this frame
  always_comb begin
    mask_above = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((IDXW'(i) > sel_idx) && mask_r[i]) begin
        mask_above = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Config, sums, published averages, publish mask, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= LOW_RST;
      high_r      <= HIGH_RST;
      thr_r       <= THR_RST;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        pub_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LOW:  low_r  <= cfg_data;
          CFG_HIGH: high_r <= cfg_data;
          CFG_THR:  thr_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.acc_en) begin
        sum_r[sel_idx] <= sum_sel + SUM_W'(in_sample);
      end
      if (cmd.scan_en) begin
        mask_r[sel_idx] <= flag;
      end
      if (cmd.sel_en) begin
        sum_r[sel_idx] <= '0;
        if (hit) begin
          pub_r[sel_idx] <= avg;
        end
      end
      if (cmd.emit_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Clamp result and output payload
  always_ff @(posedge clk) begin
    if (cmd.sel_en) begin
      direct_r     <= !in_window;
      direct_val_r <= below ? '0 : FULL_SCALE;
    end
    if (cmd.emit_en) begin
      out_channel_r <= CH_W'(sel_idx);
      out_value_r   <= direct_r ? direct_val_r : quo;
      out_last_r    <= !mask_above;
    end
  end

  assign cfg_ready        = 1'b1;
  assign status.mask_hit  = hit;
  assign status.div_busy  = div_busy;
  assign status.out_free  = out_free;
  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_scaled_value = out_value_r;
  assign out_last_of_run  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/core/adc_block_average_deadband_scaler_core.sv @@
// ADC block averager with change deadband and linear rescale, top level.
//
// Input channel (in_valid / in_stall / in_sample): one raw 12-bit sample per
// transaction, in scan order channel 0..CHANNELS-1, four rounds per frame.
// A sample is taken whenever in_valid is high while the block accumulates.
// After the last sample of a frame the block holds in_stall high while it
// evaluates: a deadband scan over all channels, then per channel a select
// step, plus, for a channel that publishes, a rescale (one quotient bit per
// cycle in the divider) and a load of the output register.
// Output channel (out_valid / out_stall): channel, scaled_value and
// last_of_run, one transaction per published channel in ascending order.
// The output register holds a result under out_stall; evaluation waits on it,
// but the next frame's samples are accepted while the last result waits.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// index 0 low_limit, 1 high_limit, 2 change_threshold, others ignored.
// Reset (rst_n, synchronous): clears sums, published averages, scan position,
// and restores register defaults 0 / 4095 / 16. Depends on adbds_pkg.
`default_nettype none

module adc_block_average_deadband_scaler_core #(
  parameter int CHANNELS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [adbds_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [adbds_pkg::CH_W-1:0]               out_channel,
  output logic [adbds_pkg::SAMPLE_W-1:0]           out_scaled_value,
  output logic                                     out_last_of_run,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [adbds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [adbds_pkg::SAMPLE_W-1:0]      cfg_data
);
  import adbds_pkg::*;

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cmd_t            cmd;
  status_t         status;
  logic [IDXW-1:0] sel_idx;

  adbds_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .sel_idx  (sel_idx)
  );

  adbds_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .sel_idx          (sel_idx),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_scaled_value (out_scaled_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire

@@ rtl/core/adbds_checker.sv @@
// adbds_checker: port-level assertions for the block, bound to the top level.
// Depends on adbds_pkg and adc_block_average_deadband_scaler_core.
`default_nettype none

module adbds_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [adbds_pkg::CH_W-1:0]          out_channel,
  input wire logic [adbds_pkg::SAMPLE_W-1:0]      out_scaled_value,
  input wire logic                                out_last_of_run,
  input wire logic                                cfg_ready
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel)
      && $stable(out_scaled_value) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // Config port never pushes back
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg_ready dropped");

  // While a non-final result of a frame waits, no sample is taken
  a_stall_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> in_stall)
    else $error("sample taken during frame evaluation");

endmodule

bind adc_block_average_deadband_scaler_core adbds_checker u_adbds_checker (.*);

`default_nettype wire
